/* sv/rfb_pkg.sv */
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared types, constants and the CRC-16 byte step of the request frame
// builder.
// ----------------------------------------------------------------------------
package rfb_pkg;

  localparam int unsigned CMD_DEPTH_DEF = 4;
  localparam int unsigned OUT_DEPTH_DEF = 2;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_TYPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd1;

  localparam logic [7:0]  MARK_BYTE      = 8'hB6;
  localparam logic [7:0]  SYNC_BYTE      = 8'h49;
  localparam logic [7:0]  FILL_BYTE      = 8'hFF;
  localparam logic [7:0]  STUFF_BYTE     = 8'h00;
  localparam logic [7:0]  LEN_BIAS       = 8'd2;
  localparam logic [15:0] CRC_POLY       = 16'h8408;
  localparam logic [7:0]  TYPE_RESET     = 8'h00;
  localparam logic [7:0]  ADDRESS_RESET  = 8'hFF;

  typedef struct packed {
    logic       start_req;
    logic [7:0] repeat_byte;
    logic [7:0] command;
    logic [7:0] param_count;
    logic [7:0] param_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    logic [7:0] device_type;
    logic [7:0] device_address;
  } cfg_t;

  // one classified item between front and back
  typedef struct packed {
    logic       is_start;
    logic       close;
    logic [7:0] data;
    logic [7:0] cmd;
    logic [7:0] len;
  } op_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

/* sv/request_frame_builder_unit.sv */
// ----------------------------------------------------------------------------
// request_frame_builder_unit
// Request frame builder: header, parameters, CRC-16 and B6/00 byte stuffing.
// The first byte of an item passes the command queue, then the output queue.
// The back sequencer emits one line byte per cycle while an op is queued and
// the output queue is not full.
// Reset (synchronous, rst_n low): queues emptied, no frame open, CRC cleared,
// device_type to 00 and device_address to FF.
// ----------------------------------------------------------------------------
module request_frame_builder_unit #(
  parameter int unsigned CMD_DEPTH = rfb_pkg::CMD_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = rfb_pkg::OUT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rfb_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [rfb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_push,
  output logic                             in_full,
  input  rfb_pkg::in_word_t                in_word,
  output logic                             out_empty,
  input  logic                             out_pop,
  output rfb_pkg::out_word_t               out_word
);

  localparam int unsigned OP_W  = $bits(rfb_pkg::op_t);
  localparam int unsigned OUT_W = $bits(rfb_pkg::out_word_t);

  rfb_pkg::cfg_t      cfg_r;
  rfb_pkg::op_t       q_op, q_head;
  rfb_pkg::out_word_t o_word;
  logic               q_push, q_pop, q_full, q_empty;
  logic               o_push, o_full;
  logic [OP_W-1:0]    q_rdata;
  logic [OUT_W-1:0]   o_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_type    <= rfb_pkg::TYPE_RESET;
      cfg_r.device_address <= rfb_pkg::ADDRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        rfb_pkg::CFG_DEVICE_TYPE:    cfg_r.device_type    <= cfg_wdata;
        rfb_pkg::CFG_DEVICE_ADDRESS: cfg_r.device_address <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full = q_full;

  rfb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_word (in_word),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_op    (q_op)
  );

  rfb_fifo #(
    .WIDTH (OP_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_op),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_head = rfb_pkg::op_t'(q_rdata);

  rfb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_word  (o_word)
  );

  rfb_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata (o_word),
    .full  (o_full),
    .pop   (out_pop),
    .rdata (o_rdata),
    .empty (out_empty)
  );

  assign out_word = rfb_pkg::out_word_t'(o_rdata);

endmodule

/* sv/rfb_fifo.sv */
// ----------------------------------------------------------------------------
// rfb_fifo
// Small synchronous queue in flops; head word is visible while not empty.
// ----------------------------------------------------------------------------
module rfb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* sv/rfb_front.sv */
// ----------------------------------------------------------------------------
// rfb_front
// Accepts input words, tracks the open frame and the parameters still due,
// and queues one classified op per useful word.
// ----------------------------------------------------------------------------
module rfb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  rfb_pkg::in_word_t in_word,
  input  logic              q_full,
  output logic              q_push,
  output rfb_pkg::op_t      q_op
);

  logic       frame_open_r, frame_open_nxt;
  logic [7:0] left_r, left_nxt;
  logic       accept;

  assign accept = in_push && !q_full;

  always_comb begin
    frame_open_nxt = frame_open_r;
    left_nxt       = left_r;
    q_push         = 1'b0;
    q_op.is_start  = in_word.start_req;
    q_op.data      = in_word.start_req ? in_word.repeat_byte : in_word.param_byte;
    q_op.cmd       = in_word.command;
    q_op.len       = in_word.param_count + rfb_pkg::LEN_BIAS;
    q_op.close     = in_word.start_req ? (in_word.param_count == 8'd0) : (left_r == 8'd1);
    if (accept) begin
      if (in_word.start_req) begin
        q_push         = 1'b1;
        left_nxt       = in_word.param_count;
        frame_open_nxt = (in_word.param_count != 8'd0);
      end else if (frame_open_r) begin
        q_push         = 1'b1;
        left_nxt       = left_r - 8'd1;
        frame_open_nxt = (left_r != 8'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      left_r       <= '0;
    end else begin
      frame_open_r <= frame_open_nxt;
      left_r       <= left_nxt;
    end
  end

endmodule

/* sv/rfb_back.sv */
// ----------------------------------------------------------------------------
// rfb_back
// Byte sequencer: walks the header, parameter and CRC bytes of each op,
// folds frame bytes into the CRC and inserts a 00 after every inner B6.
// ----------------------------------------------------------------------------
module rfb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rfb_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  rfb_pkg::op_t       q_head,
  output logic               q_pop,
  input  logic               o_full,
  output logic               o_push,
  output rfb_pkg::out_word_t o_word
);

  localparam logic [3:0] ST_MARK  = 4'd0;
  localparam logic [3:0] ST_SYNC  = 4'd1;
  localparam logic [3:0] ST_TYPE  = 4'd2;
  localparam logic [3:0] ST_ADDR  = 4'd3;
  localparam logic [3:0] ST_FILL  = 4'd4;
  localparam logic [3:0] ST_LEN   = 4'd5;
  localparam logic [3:0] ST_REP   = 4'd6;
  localparam logic [3:0] ST_CMD   = 4'd7;
  localparam logic [3:0] ST_PAR   = 4'd8;
  localparam logic [3:0] ST_CRCLO = 4'd9;
  localparam logic [3:0] ST_CRCHI = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0]  step_r, step_nxt;
  logic        begin_r, begin_nxt;
  logic        stuff_r, stuff_nxt;
  logic        stuff_last_r, stuff_last_nxt;
  logic        stuff_end_r, stuff_end_nxt;
  logic [15:0] crc_r, crc_nxt;

  logic [3:0]  step;
  logic [3:0]  step_next;
  logic [7:0]  cur_byte;
  logic        is_final;
  logic        need_stuff;
  logic        go;

  assign go   = !q_empty && !o_full;
  assign step = begin_r ? (q_head.is_start ? ST_MARK : ST_PAR) : step_r;

  always_comb begin
    case (step)
      ST_MARK:  cur_byte = rfb_pkg::MARK_BYTE;
      ST_SYNC:  cur_byte = rfb_pkg::SYNC_BYTE;
      ST_TYPE:  cur_byte = cfg.device_type;
      ST_ADDR:  cur_byte = cfg.device_address;
      ST_FILL:  cur_byte = rfb_pkg::FILL_BYTE;
      ST_LEN:   cur_byte = q_head.len;
      ST_REP:   cur_byte = q_head.data;
      ST_CMD:   cur_byte = q_head.cmd;
      ST_PAR:   cur_byte = q_head.data;
      ST_CRCLO: cur_byte = crc_r[7:0];
      ST_CRCHI: cur_byte = crc_r[15:8];
      default:  cur_byte = rfb_pkg::STUFF_BYTE;
    endcase
  end

  always_comb begin
    case (step)
      ST_CMD, ST_PAR: step_next = q_head.close ? ST_CRCLO : ST_DONE;
      ST_CRCLO:       step_next = ST_CRCHI;
      ST_CRCHI:       step_next = ST_DONE;
      ST_DONE:        step_next = ST_DONE;
      default:        step_next = step + 4'd1;
    endcase
  end

  assign is_final   = (step_next == ST_DONE);
  assign need_stuff = (cur_byte == rfb_pkg::MARK_BYTE) && (step != ST_MARK);

  always_comb begin
    step_nxt       = step_r;
    begin_nxt      = begin_r;
    stuff_nxt      = stuff_r;
    stuff_last_nxt = stuff_last_r;
    stuff_end_nxt  = stuff_end_r;
    crc_nxt        = crc_r;
    q_pop          = 1'b0;
    o_push         = 1'b0;
    o_word         = '{out_byte: rfb_pkg::STUFF_BYTE,
                       run_last: stuff_last_r,
                       frame_end: stuff_end_r};
    if (go) begin
      o_push = 1'b1;
      if (stuff_r) begin
        stuff_nxt = 1'b0;
        if (stuff_last_r) begin
          q_pop     = 1'b1;
          begin_nxt = 1'b1;
        end
      end else begin
        o_word.out_byte  = cur_byte;
        o_word.run_last  = is_final && !need_stuff;
        o_word.frame_end = (step == ST_CRCHI) && !need_stuff;
        step_nxt         = step_next;
        begin_nxt        = 1'b0;
        case (step)
          ST_MARK:  crc_nxt = rfb_pkg::crc_byte(16'h0000, rfb_pkg::MARK_BYTE);
          ST_CRCLO: crc_nxt = crc_r;
          ST_CRCHI: crc_nxt = 16'h0000;
          default:  crc_nxt = rfb_pkg::crc_byte(crc_r, cur_byte);
        endcase
        if (need_stuff) begin
          stuff_nxt      = 1'b1;
          stuff_last_nxt = is_final;
          stuff_end_nxt  = (step == ST_CRCHI);
        end else if (is_final) begin
          q_pop     = 1'b1;
          begin_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= ST_MARK;
      begin_r      <= 1'b1;
      stuff_r      <= 1'b0;
      stuff_last_r <= 1'b0;
      stuff_end_r  <= 1'b0;
      crc_r        <= '0;
    end else begin
      step_r       <= step_nxt;
      begin_r      <= begin_nxt;
      stuff_r      <= stuff_nxt;
      stuff_last_r <= stuff_last_nxt;
      stuff_end_r  <= stuff_end_nxt;
      crc_r        <= crc_nxt;
    end
  end

  a_stuff_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (go && stuff_r) |-> (o_word.out_byte == rfb_pkg::STUFF_BYTE))
    else $error("stuffed byte not zero");

  a_stuff_after_mark: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stuff_r) |-> $past(o_push && o_word.out_byte == rfb_pkg::MARK_BYTE))
    else $error("stuff pending without a preceding B6");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (o_push && o_word.frame_end) |-> o_word.run_last)
    else $error("frame end not on the last byte of its op");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (o_push && o_word.run_last))
    else $error("op retired without its last byte");

endmodule
